>>> hdl/aspd_pkg.sv
// shared constants for the switch position decoder
package aspd_pkg;

    localparam int NUM_POSITIONS   = 11;
    localparam int POS_W           = 4;
    localparam int THRESH_W        = 12;
    localparam int THRESH_RESET    = 64;
    localparam int AVG_COUNT_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // trip points of the resistor ladder, ascending; the last one is never reached
    localparam int unsigned TRIP_POINTS [NUM_POSITIONS] = '{
        210, 617, 1027, 1435, 1844, 2254, 2665, 3075, 3484, 3888, 5000
    };

endpackage

>>> hdl/adc_switch_position_decoder_top.sv
// top level of the rotary switch position decoder
//
// Decodes a rotary switch position from a stream of ADC samples of its
// resistor-ladder wiper. Samples are grouped into back-to-back windows of
// AVG_COUNT beats; the last beat of each window yields one result beat.
// A window is steady when its largest step between consecutive samples
// is strictly below the stability threshold; then the window average is
// matched against the ladder trip points and the new position (0..10) is
// stored and sent with tuser high. Otherwise the stored position is sent
// again with tuser low. One sample beat is taken every cycle unless the
// input stalls as described below. A window's result is registered in
// the window slot, then goes through the trip-point compare stage into
// the output register. The accumulator, a one-entry window slot and the
// output register make up the pipeline, so sample beats keep flowing
// while a result waits on m_axis_tready; the input stalls only on a
// window's last beat while the slot is still full. The threshold resets
// to 64 and is written through the cfg channel; the user must write it
// only while the block is idle, the block itself does not enforce this.
module adc_switch_position_decoder_top
    import aspd_pkg::*;
#(
    parameter int AVG_COUNT   = AVG_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // sample stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_axis_tdata,  // sample
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // position
    output logic                                 m_axis_tuser,  // stable
    // threshold write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [THRESH_W-1:0]                  cfg_data       // stability_threshold
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_COUNT);

    logic [THRESH_W-1:0]    threshold_reg, threshold_next;

    // window slot between accumulator and decoder
    logic                   win_valid;
    logic                   win_ready;
    logic [SUM_W-1:0]       win_sum;
    logic [SAMPLE_BITS-1:0] win_step;
    logic [POS_W-1:0]       position;

    // threshold register, always writable
    assign cfg_ready      = 1'b1;
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESH_W'(THRESH_RESET);
        end else begin
            threshold_reg <= threshold_next;
        end
    end

    // running sum and largest step over the window
    aspd_window_acc #(
        .AVG_COUNT   (AVG_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win_sum   (win_sum),
        .win_step  (win_step)
    );

    // steady check, trip point decode and result register
    aspd_decoder #(
        .AVG_COUNT   (AVG_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_dec (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .threshold    (threshold_reg),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win_sum      (win_sum),
        .win_step     (win_step),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_position (position),
        .out_stable   (m_axis_tuser)
    );

    assign m_axis_tdata = 8'(position);

    // decoded position never leaves the ladder range
    a_pos_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (position <= POS_W'(NUM_POSITIONS - 1)))
        else $error("position out of range");

    // input only backs up while a finished window waits
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> win_valid)
        else $error("input stalled with empty window slot");

    // a zero threshold never lets a window count as steady
    a_zero_thresh : assert property (@(posedge aclk) disable iff (!aresetn)
        (win_valid && win_ready && threshold_reg == '0) |=> !m_axis_tuser)
        else $error("steady result with zero threshold");

endmodule

>>> hdl/aspd_window_acc.sv
// per-window sum and largest step accumulator
module aspd_window_acc
    import aspd_pkg::*;
#(
    parameter int AVG_COUNT   = AVG_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(AVG_COUNT)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   win_valid,
    input  logic                   win_ready,
    output logic [SUM_W-1:0]       win_sum,
    output logic [SAMPLE_BITS-1:0] win_step
);

    localparam int CNT_W = $clog2(AVG_COUNT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_COUNT - 1);

    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [SUM_W-1:0]       sum_reg,    sum_next;
    logic [SAMPLE_BITS-1:0] prev_reg,   prev_next;
    logic [SAMPLE_BITS-1:0] step_reg,   step_next;
    logic                   wvalid_reg, wvalid_next;
    logic [SUM_W-1:0]       wsum_reg,   wsum_next;
    logic [SAMPLE_BITS-1:0] wstep_reg,  wstep_next;

    logic                   accept;
    logic                   first;
    logic                   last;
    logic [SAMPLE_BITS-1:0] diff;

    assign first    = (count_reg == '0);
    assign last     = (count_reg == CNT_LAST);
    // a last sample needs the window slot free
    assign in_ready = !(wvalid_reg && last);
    assign accept   = in_valid && in_ready;
    assign diff     = (in_sample >= prev_reg) ? (in_sample - prev_reg) : (prev_reg - in_sample);

    always_comb begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        prev_next   = prev_reg;
        step_next   = step_reg;
        wvalid_next = wvalid_reg;
        wsum_next   = wsum_reg;
        wstep_next  = wstep_reg;
        if (wvalid_reg && win_ready) begin
            wvalid_next = 1'b0;
        end
        if (accept) begin
            prev_next = in_sample;
            if (first) begin
                sum_next  = SUM_W'(in_sample);
                step_next = '0;
            end else begin
                sum_next  = sum_reg + SUM_W'(in_sample);
                step_next = (diff > step_reg) ? diff : step_reg;
            end
            if (last) begin
                count_next  = '0;
                wvalid_next = 1'b1;
                wsum_next   = sum_next;
                wstep_next  = step_next;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            prev_reg   <= '0;
            step_reg   <= '0;
            wvalid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            prev_reg   <= prev_next;
            step_reg   <= step_next;
            wvalid_reg <= wvalid_next;
        end
        wsum_reg  <= wsum_next;
        wstep_reg <= wstep_next;
    end

    assign win_valid = wvalid_reg;
    assign win_sum   = wsum_reg;
    assign win_step  = wstep_reg;

endmodule

>>> hdl/aspd_decoder.sv
// trip point compare, held position and output register
module aspd_decoder
    import aspd_pkg::*;
#(
    parameter int AVG_COUNT   = AVG_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(AVG_COUNT)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [THRESH_W-1:0]    threshold,
    input  logic                   win_valid,
    output logic                   win_ready,
    input  logic [SUM_W-1:0]       win_sum,
    input  logic [SAMPLE_BITS-1:0] win_step,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [POS_W-1:0]       out_position,
    output logic                   out_stable
);

    localparam int BOUND_W = $clog2((TRIP_POINTS[NUM_POSITIONS-2] + 1) * AVG_COUNT + 1);
    localparam int CMP_W   = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;
    localparam int STEP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    logic                      ovalid_reg, ovalid_next;
    logic [POS_W-1:0]          pos_reg,    pos_next;
    logic                      stable_reg, stable_next;
    logic [POS_W-1:0]          held_reg,   held_next;

    logic [CMP_W-1:0]          sum_ext;
    logic [NUM_POSITIONS-2:0]  above;
    logic [POS_W-1:0]          decoded;
    logic                      steady;
    logic                      take;

    assign sum_ext = CMP_W'(win_sum);

    // avg > tp  <=>  sum >= (tp + 1) * AVG_COUNT, so no divide is needed
    for (genvar g = 0; g < NUM_POSITIONS - 1; g++) begin : g_trip
        localparam int unsigned BOUND = (TRIP_POINTS[g] + 1) * AVG_COUNT;
        assign above[g] = (sum_ext >= CMP_W'(BOUND));
    end

    assign decoded   = POS_W'(NUM_POSITIONS - 1) - POS_W'($countones(above));
    assign steady    = (STEP_W'(win_step) < STEP_W'(threshold));
    assign win_ready = !ovalid_reg || out_ready;
    assign take      = win_valid && win_ready;

    always_comb begin
        ovalid_next = ovalid_reg;
        pos_next    = pos_reg;
        stable_next = stable_reg;
        held_next   = held_reg;
        if (take) begin
            ovalid_next = 1'b1;
            stable_next = steady;
            pos_next    = steady ? decoded : held_reg;
            held_next   = pos_next;
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
            held_reg   <= '0;
        end else begin
            ovalid_reg <= ovalid_next;
            held_reg   <= held_next;
        end
        pos_reg    <= pos_next;
        stable_reg <= stable_next;
    end

    assign out_valid    = ovalid_reg;
    assign out_position = pos_reg;
    assign out_stable   = stable_reg;

endmodule

>>> test/adc_switch_position_decoder_top_tb.sv
// self-checking testbench for the rotary switch position decoder
module adc_switch_position_decoder_top_tb;
    import aspd_pkg::*;

    localparam int TDATA_W    = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int WIN_LEN    = AVG_COUNT_DEF;
    localparam int CODE_MAX   = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES     = 8;
    localparam int PHASE_WINS = 12;

    typedef struct {
        logic [TDATA_W-1:0] data;
        bit                 drain;   // wait for all results before this beat
    } sample_beat_t;

    typedef struct {
        logic [POS_W-1:0] position;
        logic             stable;
    } switch_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [THRESH_W-1:0] cfg_data      = '0;

    adc_switch_position_decoder_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    sample_beat_t   sample_queue[$];
    switch_result_t decoded_queue[$];
    int             error_count = 0;
    int             idle_cycles = 0;

    // decoder state mirror
    logic [THRESH_W-1:0]        expected_threshold = THRESH_W'(THRESH_RESET);
    int unsigned                win_sum            = 0;
    logic [SAMPLE_BITS_DEF-1:0] last_sample        = '0;
    logic [SAMPLE_BITS_DEF-1:0] max_step           = '0;
    int                         beat_count         = 0;
    logic [POS_W-1:0]           held_pos           = '0;

    task automatic decode_sample(input logic [TDATA_W-1:0] raw);
        logic [SAMPLE_BITS_DEF-1:0] s;
        logic [SAMPLE_BITS_DEF-1:0] d;
        int unsigned                avg;
        int                         idx;
        bit                         steady;
        s = raw[SAMPLE_BITS_DEF-1:0];
        if (beat_count == 0) begin
            win_sum  = 32'(s);
            max_step = '0;
        end else begin
            d = (s >= last_sample) ? s - last_sample : last_sample - s;
            if (d > max_step) max_step = d;
            win_sum += 32'(s);
        end
        last_sample = s;
        beat_count++;
        if (beat_count == WIN_LEN) begin
            beat_count = 0;
            steady = (max_step < expected_threshold);
            if (steady) begin
                avg = win_sum / WIN_LEN;
                idx = 0;
                while (idx < NUM_POSITIONS - 1 && TRIP_POINTS[idx] < avg) idx++;
                held_pos = POS_W'(NUM_POSITIONS - 1 - idx);
            end
            decoded_queue.push_back('{position: held_pos, stable: steady});
        end
    endtask

    // stimulus helpers
    function automatic int clamp_code(input int v);
        return (v < 0) ? 0 : (v > CODE_MAX) ? CODE_MAX : v;
    endfunction

    task automatic push_beat(input int s, input bit drain);
        sample_beat_t b;
        b.data  = TDATA_W'(s);
        // junk above the sample field now and then
        if ($urandom_range(0, 3) == 0)
            b.data[TDATA_W-1:SAMPLE_BITS_DEF] =
                (TDATA_W - SAMPLE_BITS_DEF)'($urandom_range(0, 15));
        b.drain = drain;
        sample_queue.push_back(b);
    endtask

    // wandering window: steps up to limit, one step of exactly exact_step if >= 0
    task automatic push_window(input int level, input int limit, input int exact_step,
                               input bit drain);
        int prev;
        int cur;
        int at;
        int k;
        at   = $urandom_range(1, WIN_LEN - 1);
        prev = clamp_code(level);
        push_beat(prev, drain);
        for (int i = 1; i < WIN_LEN; i++) begin
            k = (i == at && exact_step >= 0) ? exact_step : $urandom_range(0, limit);
            if ($urandom_range(0, 1) == 0)
                cur = (prev + k <= CODE_MAX) ? prev + k : prev - k;
            else
                cur = (prev - k >= 0) ? prev - k : prev + k;
            cur = clamp_code(cur);
            push_beat(cur, 1'b0);
            prev = cur;
        end
    endtask

    task automatic push_random_window(input int thr, input bit drain);
        int pick;
        int idx;
        int level;
        int lim;
        pick = $urandom_range(0, 9);
        idx  = $urandom_range(0, NUM_POSITIONS - 1);
        if (idx == NUM_POSITIONS - 1)
            level = $urandom_range(TRIP_POINTS[NUM_POSITIONS - 2] + 1, CODE_MAX);
        else
            level = int'(TRIP_POINTS[idx]) + $urandom_range(0, 8) - 4;
        lim = (thr > 1) ? $urandom_range(0, thr - 1) : $urandom_range(0, 2);
        if (lim > 40 && $urandom_range(0, 1) == 0) lim = $urandom_range(0, 40);
        case (pick)
            6: begin
                // flat window right on a trip point or one above it, or at full scale for the top index
                level = (idx == NUM_POSITIONS - 1) ? CODE_MAX :
                        int'(TRIP_POINTS[idx]) + $urandom_range(0, 1);
                push_window(level, 0, -1, drain);
            end
            7: begin
                for (int i = 0; i < WIN_LEN; i++)
                    push_beat($urandom_range(0, CODE_MAX), drain && i == 0);
            end
            8: begin
                // largest step right at the threshold edge
                push_window(level, (thr > 0) ? thr - 1 : 0,
                            clamp_code(thr - 1 + $urandom_range(0, 2)), drain);
            end
            9: begin
                push_window(level, lim, $urandom_range(thr, CODE_MAX), drain);
            end
            default: begin
                push_window(level, lim, -1, drain);
            end
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (sample_queue.size() != 0 || s_axis_tvalid || decoded_queue.size() != 0);
        // pipeline holds a partial window at most, give it time to settle
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_threshold(input int v);
        @(posedge aclk);
        cfg_data  <= THRESH_W'(v);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // sample driver, bursts and gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        sample_beat_t b;
        bit           send;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the beat until taken
        end else begin
            send = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (burst_left > 0) begin
                if (sample_queue.size() != 0 &&
                    !(sample_queue[0].drain && (s_axis_tvalid || decoded_queue.size() != 0)))
                    send = 1'b1;
                if (send) burst_left--;
            end else begin
                gap_left--;
            end
            if (send) begin
                b = sample_queue.pop_front();
                s_axis_tdata  <= b.data;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver stall pattern
    int mode       = 0;
    int mode_left  = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 30);
                    end
                end
            endcase
        end
    end

    // result checker, sample tracker and watchdog
    always @(posedge aclk) begin
        switch_result_t want;
        bit             moved;
        if (aresetn) begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (decoded_queue.size() == 0) begin
                    $error("result beat with no window pending: tdata %0h tuser %0b",
                           m_axis_tdata, m_axis_tuser);
                    error_count++;
                end else begin
                    want = decoded_queue.pop_front();
                    if (m_axis_tdata !== {{(8 - POS_W){1'b0}}, want.position}) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.stable) begin
                        $error("stable mismatch: expected %0b, actual %0b",
                               want.stable, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                decode_sample(s_axis_tdata);
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                expected_threshold = cfg_data;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("adc_switch_position_decoder_top verification failed");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        int thr;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // flat zero window then flat full-scale window with junk upper bits;
        // the jump between them must not count as a step
        for (int i = 0; i < WIN_LEN; i++) push_beat(0, 1'b0);
        for (int i = 0; i < WIN_LEN; i++) begin
            sample_queue.push_back('{data: {TDATA_W{1'b1}}, drain: 1'b0});
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: thr = 0;
                1: thr = CODE_MAX;
                2: thr = 1;
                3: thr = THRESH_RESET;
                4: thr = $urandom_range(2, 400);
                5: thr = $urandom_range(0, CODE_MAX);
                6: thr = 32;
                default: thr = 300;
            endcase
            write_threshold(thr);
            for (int w = 0; w < PHASE_WINS; w++)
                push_random_window(thr, w == PHASE_WINS / 2);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("adc_switch_position_decoder_top verification clean");
        end else begin
            $display("adc_switch_position_decoder_top verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/aspd_pkg.sv
hdl/aspd_window_acc.sv
hdl/aspd_decoder.sv
hdl/adc_switch_position_decoder_top.sv
test/adc_switch_position_decoder_top_tb.sv
